>>> rtl/core/kad_pkg.sv
// Shared types, constants and helpers for the keyed arithmetic decoder.
package kad_pkg;

   localparam int MAX_SPECIES       = 256;
   localparam int COUNT_WIDTH       = 24;
   localparam int MAX_INTERVAL_BITS = 26;
   localparam int BUF_CAP           = MAX_INTERVAL_BITS + 8;

   localparam int TOT_W  = 24;
   localparam int BITS_W = 5;
   localparam int IDX_W  = $clog2(MAX_SPECIES);
   localparam int N_W    = IDX_W + 1;
   localparam int VW     = MAX_INTERVAL_BITS + 1;
   localparam int FILL_W = $clog2(BUF_CAP + 1);
   localparam int BPOS_W = $clog2(BUF_CAP);
   localparam int PROD_W = VW + TOT_W;
   localparam int CNT_W  = $clog2(VW);

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_PUSH = 2'd1;

   localparam logic [1:0] CSR_TOTAL   = 2'd0;
   localparam logic [1:0] CSR_SPECIES = 2'd1;
   localparam logic [1:0] CSR_BITS    = 2'd2;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LOADED   = 3'd1,
      ST_TAKEN    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NEED     = 3'd4,
      ST_NOMATCH  = 3'd5,
      ST_MISMATCH = 3'd6,
      ST_HALT     = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      A_NOP, A_LOAD, A_PUSH, A_BEGIN, A_PASS_INIT, A_MUL, A_DIV_LOAD,
      A_DIV_STEP, A_EVAL, A_COMMIT, A_SYM, A_SCALE
   } action_type;

   typedef enum logic [1:0] {
      SC_DONE, SC_STEP, SC_FAIL
   } scale_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  entry_index;
      logic [7:0]  entry_symbol;
      logic [23:0] entry_count;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  symbol;
      status_type  status;
      logic [23:0] remaining;
   } rsp_type;

   typedef struct packed {
      action_type       action;
      logic [IDX_W-1:0] index;
      logic             pass2;
      logic             respond;
      status_type       code;
      logic             use_sym;
      logic             halt;
   } cmd_type;

   typedef struct packed {
      logic           halted;
      logic           left_zero;
      logic           short_bits;
      logic           buf_full;
      logic           range_bad;
      logic [N_W-1:0] n;
      logic           hit_one;
      scale_type      scale;
   } stat_type;

   function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] b);
      logic [BITS_W-1:0] r;
      r = b;
      if (r < BITS_W'(2)) r = BITS_W'(2);
      if (r > BITS_W'(MAX_INTERVAL_BITS)) r = BITS_W'(MAX_INTERVAL_BITS);
      return r;
   endfunction

endpackage

>>> rtl/core/kad_ram.sv
// Generic single-port-write, registered-read RAM.
module kad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/kad_datapath.sv
// Decoder datapath: config, interval, bit buffer, tables, divider, response.
module kad_datapath (
   input  logic             clock,
   input  logic             reset,
   input  kad_pkg::req_type req_data,
   input  kad_pkg::cmd_type cmd,
   output kad_pkg::stat_type stat,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output logic             rsp_strobe,
   output kad_pkg::rsp_type rsp_data
);
   import kad_pkg::*;

   logic [TOT_W-1:0]   total_ff, total_in;
   logic [8:0]         species_ff, species_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [VW-1:0]      low_ff, low_in, high_ff, high_in;
   logic [BUF_CAP-1:0] buf_ff, buf_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TOT_W-1:0]   left_ff, left_in;
   logic               halted_ff, halted_in;
   logic [VW-1:0]      tag_ff, tag_in, range_ff, range_in;
   logic               key1_ff, key1_in, rbad_ff, rbad_in;
   logic [TOT_W-1:0]   cs_ff, cs_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [TOT_W:0]     rem_ff, rem_in;
   logic [VW-1:0]      dvd_ff, dvd_in, quo_ff, quo_in, prev_ff, prev_in;
   logic [IDX_W-1:0]   imin_ff, imin_in, k_ff, k_in;
   logic [1:0]         hits_ff, hits_in;
   logic [VW-1:0]      lok_ff, lok_in, endk_ff, endk_in;
   logic [7:0]         sym_ff, sym_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [BITS_W-1:0]  eb;
   logic [VW-1:0]      iv, half, quarter, tq;
   logic [TOT_W-1:0]   tot;
   logic [FILL_W-1:0]  sh;
   logic [VW-1:0]      tag_now, rng_now;
   logic [7:0]         sym_rd;
   logic [COUNT_WIDTH-1:0] cnt_rd;
   logic [IDX_W-1:0]   rd_addr;
   logic [TOT_W:0]     sum, trial;
   logic [TOT_W-1:0]   cs_new;
   logic [VW-1:0]      e_val, lo_a, end_a, hdec;
   logic               inc_lo, inc_end, hit;
   logic               bit0, bit1, e1, e2, e3;
   logic [BPOS_W-1:0]  p0, p1;
   scale_type          scale;

   // derived interval constants
   always_comb begin
      eb      = eff_bits(bits_ff);
      iv      = VW'(1) << eb;
      half    = iv >> 1;
      quarter = iv >> 2;
      tq      = quarter + half;
      tot     = (total_ff == '0) ? TOT_W'(1) : total_ff;
      sh      = fill_ff - FILL_W'(eb);
      tag_now = VW'(buf_ff >> sh) & (iv - VW'(1));
      rng_now = high_ff - low_ff + VW'(1);
   end

   assign rd_addr = (cmd.action == A_COMMIT) ? k_ff : cmd.index;

   kad_ram #(.WIDTH(8), .DEPTH(MAX_SPECIES)) u_sym_ram (
      .clock   (clock),
      .wr_en   (cmd.action == A_LOAD),
      .wr_addr (req_data.entry_index[IDX_W-1:0]),
      .wr_data (req_data.entry_symbol),
      .rd_addr (rd_addr),
      .rd_data (sym_rd)
   );

   kad_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_SPECIES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cmd.action == A_LOAD),
      .wr_addr (req_data.entry_index[IDX_W-1:0]),
      .wr_data (req_data.entry_count[COUNT_WIDTH-1:0]),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   // rescale classification
   always_comb begin
      p0   = BPOS_W'(fill_ff - FILL_W'(1));
      p1   = BPOS_W'(fill_ff - FILL_W'(2));
      bit0 = (fill_ff != '0) ? buf_ff[p0] : 1'b0;
      bit1 = (fill_ff >= FILL_W'(2)) ? buf_ff[p1] : 1'b0;
      e1   = high_ff < half;
      e2   = (low_ff >= half) && (high_ff < iv);
      e3   = (low_ff >= quarter) && (high_ff < tq);
      if (e1) begin
         scale = ((fill_ff != '0) && !bit0) ? SC_STEP : SC_FAIL;
      end else if (e2) begin
         scale = ((fill_ff != '0) && bit0) ? SC_STEP : SC_FAIL;
      end else if (e3) begin
         scale = ((fill_ff >= FILL_W'(2)) && (bit0 != bit1)) ? SC_STEP : SC_FAIL;
      end else begin
         scale = SC_DONE;
      end
   end

   always_comb begin
      sum     = {1'b0, cs_ff} + (TOT_W+1)'(cnt_rd);
      cs_new  = (sum >= {1'b0, tot}) ? tot : sum[TOT_W-1:0];
      trial   = {rem_ff[TOT_W-1:0], dvd_ff[VW-1]};
      e_val   = low_ff + quo_ff;
      inc_lo  = key1_ff && (cmd.index != '0) && (cmd.index <= imin_ff);
      inc_end = key1_ff && ((cmd.index == '0) || (cmd.index < imin_ff));
      lo_a    = prev_ff + VW'(inc_lo);
      end_a   = e_val + VW'(inc_end);
      hit     = (tag_ff >= lo_a) && (tag_ff < end_a);
      hdec    = endk_ff - VW'(1);
   end

   always_comb begin
      total_in = total_ff; species_in = species_ff; bits_in = bits_ff;
      low_in = low_ff; high_in = high_ff; buf_in = buf_ff; fill_in = fill_ff;
      left_in = left_ff; halted_in = halted_ff;
      tag_in = tag_ff; range_in = range_ff; key1_in = key1_ff; rbad_in = rbad_ff;
      cs_in = cs_ff; prod_in = prod_ff; rem_in = rem_ff; dvd_in = dvd_ff;
      quo_in = quo_ff; prev_in = prev_ff; imin_in = imin_ff; k_in = k_ff;
      hits_in = hits_ff; lok_in = lok_ff; endk_in = endk_ff; sym_in = sym_ff;

      case (cmd.action)
         A_PUSH: begin
            buf_in  = {buf_ff[BUF_CAP-9:0], req_data.data_byte};
            fill_in = fill_ff + FILL_W'(8);
         end
         A_BEGIN: begin
            tag_in   = tag_now;
            key1_in  = req_data.data_byte == 8'd1;
            range_in = rng_now;
            rbad_in  = (high_ff < low_ff) || (rng_now < quarter);
            cs_in    = '0;
            prev_in  = low_ff;
            imin_in  = '0;
            hits_in  = '0;
            sym_in   = '0;
         end
         A_PASS_INIT: begin
            cs_in   = '0;
            prev_in = low_ff;
         end
         A_MUL: begin
            cs_in   = cs_new;
            prod_in = PROD_W'(range_ff) * PROD_W'(cs_new);
         end
         A_DIV_LOAD: begin
            rem_in = {1'b0, prod_ff[PROD_W-1:VW]};
            dvd_in = prod_ff[VW-1:0];
            quo_in = '0;
         end
         A_DIV_STEP: begin
            if (trial >= {1'b0, tot}) begin
               rem_in = trial - {1'b0, tot};
               quo_in = {quo_ff[VW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[VW-2:0], 1'b0};
            end
            dvd_in = {dvd_ff[VW-2:0], 1'b0};
         end
         A_EVAL: begin
            if (!cmd.pass2) begin
               if (e_val >= prev_ff + VW'(2)) imin_in = cmd.index;
            end else if (hit) begin
               hits_in = (hits_ff == 2'd2) ? 2'd2 : hits_ff + 2'd1;
               k_in    = cmd.index;
               lok_in  = lo_a;
               endk_in = end_a;
            end
            prev_in = e_val;
         end
         A_COMMIT: begin
            low_in  = lok_ff;
            high_in = (hdec > iv - VW'(1)) ? iv - VW'(1) : hdec;
            left_in = left_ff - TOT_W'(1);
         end
         A_SYM: begin
            sym_in = sym_rd;
         end
         A_SCALE: begin
            if (scale == SC_STEP) begin
               fill_in = fill_ff - FILL_W'(1);
               if (e1) begin
                  low_in  = low_ff << 1;
                  high_in = (high_ff << 1) | VW'(1);
               end else if (e2) begin
                  low_in  = (low_ff << 1) - iv;
                  high_in = ((high_ff << 1) | VW'(1)) - iv;
               end else begin
                  low_in     = (low_ff << 1) - half;
                  high_in    = ((high_ff << 1) | VW'(1)) - half;
                  buf_in[p1] = bit0;
               end
            end
         end
         default: begin
         end
      endcase

      if (cmd.halt) halted_in = 1'b1;

      // a register write restarts decoding; the tables are kept
      if (csr_we && (csr_index == CSR_TOTAL || csr_index == CSR_SPECIES
                     || csr_index == CSR_BITS)) begin
         if (csr_index == CSR_TOTAL)   total_in   = csr_wdata;
         if (csr_index == CSR_SPECIES) species_in = csr_wdata[8:0];
         if (csr_index == CSR_BITS)    bits_in    = csr_wdata[BITS_W-1:0];
         low_in    = '0;
         high_in   = (VW'(1) << eff_bits(bits_in)) - VW'(1);
         buf_in    = '0;
         fill_in   = '0;
         left_in   = total_in;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= TOT_W'(1);
         species_ff   <= 9'd1;
         bits_ff      <= BITS_W'(MAX_INTERVAL_BITS);
         low_ff       <= '0;
         high_ff      <= (VW'(1) << MAX_INTERVAL_BITS) - VW'(1);
         buf_ff       <= '0;
         fill_ff      <= '0;
         left_ff      <= TOT_W'(1);
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         species_ff   <= species_in;
         bits_ff      <= bits_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in; range_ff <= range_in; key1_ff <= key1_in; rbad_ff <= rbad_in;
      cs_ff <= cs_in; prod_ff <= prod_in; rem_ff <= rem_in; dvd_ff <= dvd_in;
      quo_ff <= quo_in; prev_ff <= prev_in; imin_ff <= imin_in; k_ff <= k_in;
      hits_ff <= hits_in; lok_ff <= lok_in; endk_ff <= endk_in; sym_ff <= sym_in;
      if (cmd.respond) begin
         rsp_ff.symbol    <= cmd.use_sym ? sym_ff : 8'd0;
         rsp_ff.status    <= cmd.code;
         rsp_ff.remaining <= left_ff;
      end
   end

   always_comb begin
      stat.halted     = halted_ff;
      stat.left_zero  = left_ff == '0;
      stat.short_bits = fill_ff < FILL_W'(eb);
      stat.buf_full   = (fill_ff + FILL_W'(8)) > FILL_W'(BUF_CAP);
      stat.range_bad  = rbad_ff;
      stat.n          = (species_ff > 9'(MAX_SPECIES)) ? N_W'(MAX_SPECIES)
                                                       : N_W'(species_ff);
      stat.hit_one    = hits_ff == 2'd1;
      stat.scale      = scale;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> rtl/core/kad_ctrl.sv
// Decoder sequencer: op dispatch, two table passes, divider count, rescale.
module kad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        op,
   input  kad_pkg::stat_type stat,
   output kad_pkg::cmd_type  cmd,
   output logic              busy
);
   import kad_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CHECK = 10'b0000000010,
      S_FETCH = 10'b0000000100,
      S_MUL   = 10'b0000001000,
      S_DLOAD = 10'b0000010000,
      S_DIV   = 10'b0000100000,
      S_EVAL  = 10'b0001000000,
      S_PASS2 = 10'b0010000000,
      S_PICK  = 10'b0100000000,
      S_SCALE = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [N_W-1:0]    idx_ff, idx_in;
   logic              pass2_ff, pass2_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sym_wait_ff, sym_wait_in;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pass2_in    = pass2_ff;
      cnt_in      = cnt_ff;
      sym_wait_in = 1'b0;
      cmd         = '0;
      cmd.index   = idx_ff[IDX_W-1:0];
      cmd.pass2   = pass2_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.respond = 1'b1;
               if (op == OP_LOAD) begin
                  cmd.action = A_LOAD;
                  cmd.code   = ST_LOADED;
               end else if (stat.halted) begin
                  cmd.code = ST_HALT;
               end else if (op == OP_PUSH) begin
                  if (stat.buf_full) begin
                     cmd.code = ST_FULL;
                  end else begin
                     cmd.action = A_PUSH;
                     cmd.code   = ST_TAKEN;
                  end
               end else if (stat.left_zero) begin
                  cmd.code = ST_HALT;
               end else if (stat.short_bits) begin
                  cmd.code = ST_NEED;
               end else begin
                  cmd.respond = 1'b0;
                  cmd.action  = A_BEGIN;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            idx_in   = '0;
            pass2_in = 1'b0;
            if (stat.range_bad) begin
               cmd.halt    = 1'b1;
               cmd.respond = 1'b1;
               cmd.code    = ST_MISMATCH;
               state_in    = S_IDLE;
            end else if (stat.n == '0) begin
               cmd.halt    = 1'b1;
               cmd.respond = 1'b1;
               cmd.code    = ST_NOMATCH;
               state_in    = S_IDLE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_MUL;
         S_MUL: begin
            cmd.action = A_MUL;
            state_in   = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.action = A_DIV_LOAD;
            cnt_in     = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.action = A_DIV_STEP;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VW - 1)) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.action = A_EVAL;
            if (idx_ff + N_W'(1) < stat.n) begin
               idx_in   = idx_ff + N_W'(1);
               state_in = S_FETCH;
            end else if (!pass2_ff) begin
               state_in = S_PASS2;
            end else begin
               state_in = S_PICK;
            end
         end
         S_PASS2: begin
            cmd.action = A_PASS_INIT;
            idx_in     = '0;
            pass2_in   = 1'b1;
            state_in   = S_FETCH;
         end
         S_PICK: begin
            if (!stat.hit_one) begin
               cmd.halt    = 1'b1;
               cmd.respond = 1'b1;
               cmd.code    = ST_NOMATCH;
               state_in    = S_IDLE;
            end else begin
               cmd.action  = A_COMMIT;
               sym_wait_in = 1'b1;
               state_in    = S_SCALE;
            end
         end
         S_SCALE: begin
            if (sym_wait_ff) begin
               // symbol read from the table lands this cycle
               cmd.action = A_SYM;
            end else begin
               cmd.action = A_SCALE;
               case (stat.scale)
                  SC_DONE: begin
                     cmd.respond = 1'b1;
                     cmd.use_sym = 1'b1;
                     cmd.code    = ST_OK;
                     state_in    = S_IDLE;
                  end
                  SC_FAIL: begin
                     cmd.halt    = 1'b1;
                     cmd.respond = 1'b1;
                     cmd.use_sym = 1'b1;
                     cmd.code    = ST_MISMATCH;
                     state_in    = S_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         pass2_ff    <= 1'b0;
         cnt_ff      <= '0;
         sym_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         pass2_ff    <= pass2_in;
         cnt_ff      <= cnt_in;
         sym_wait_ff <= sym_wait_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

>>> rtl/core/keyed_arithmetic_decoder.sv
// Top level of the keyed arithmetic decoder: sequencer plus datapath.
// Load, push and refused beats: result strobe one cycle after the beat, busy stays low.
// Decode beat: two table passes, each entry fetched, multiplied, run through the divider
// and evaluated, then one rescale step per cycle.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-high reset: registers to defaults, interval restarted, tables left undefined.
module keyed_arithmetic_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kad_pkg::req_type req_data,
   output logic             rsp_strobe,
   output kad_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   import kad_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     start_ok;

   // a beat is taken only while the sequencer is idle
   assign start_ok = start & ~busy;

   // sequencer: dispatches each beat, walks the table twice per decode
   // (first pass finds the last wide entry, second applies the key shift
   // and counts matches), then steps E1/E2/E3 rescaling one bit a cycle
   kad_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start_ok),
      .op    (req_data.op),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath: tables, interval, bit buffer, shared multiplier and
   // bit-serial divider, result register
   kad_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/core/kad_checker.sv
// Port-level checker for the keyed arithmetic decoder, with its bind.
module kad_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input kad_pkg::req_type req_data,
   input logic             rsp_strobe,
   input kad_pkg::rsp_type rsp_data
);
   import kad_pkg::*;

   // results only leave once the block is idle again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   // every beat either answers next cycle or starts a decode
   a_beat_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("beat neither answered nor started");

   // a decoded symbol always follows a busy period
   a_ok_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_OK) |-> $past(busy))
      else $error("symbol result without decode");

   // table load answers directly after its beat
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_LOADED)
         |-> $past(start && !busy && req_data.op == OP_LOAD))
      else $error("load answer without load beat");

endmodule

bind keyed_arithmetic_decoder kad_checker u_checker (.*);

>>> tb/sv/keyed_arithmetic_decoder_test.sv
// Self-checking testbench for the keyed arithmetic decoder.
`timescale 1ns / 1ps

module keyed_arithmetic_decoder_test;
   import kad_pkg::*;

   // decode beats: op 2 is the normal form, op 3 aliases it
   localparam logic [1:0] OP_DECODE     = 2'd2;
   localparam logic [1:0] OP_DECODE_ALT = 2'd3;
   localparam int         STALL_LIMIT   = 200000;
   localparam int         ITEM_TARGET   = 1000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   always #5 clock = ~clock;

   keyed_arithmetic_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Decoder state as the block should hold it: table, interval,
   // bit buffer and registers.
   // ---------------------------------------------------------------
   typedef struct {
      logic [7:0]      sym_tab [256];
      logic [23:0]     cnt_tab [256];
      longint unsigned lo_b;
      longint unsigned hi_b;
      longint unsigned bbuf;
      int unsigned     fill;
      logic [23:0]     left;
      bit              halted;
      logic [23:0]     total;
      logic [8:0]      species;
      logic [4:0]      ibits;
   } dec_state_t;

   function automatic int unsigned width_of(input dec_state_t m);
      int unsigned b;
      b = m.ibits;
      if (b < 2) b = 2;
      if (b > MAX_INTERVAL_BITS) b = MAX_INTERVAL_BITS;
      return b;
   endfunction

   function automatic void restart_interval(inout dec_state_t m);
      m.lo_b   = 0;
      m.hi_b   = (64'd1 << width_of(m)) - 1;
      m.bbuf   = 0;
      m.fill   = 0;
      m.left   = m.total;
      m.halted = 1'b0;
   endfunction

   function automatic void power_on(inout dec_state_t m);
      m.total   = 24'd1;
      m.species = 9'd1;
      m.ibits   = 5'd26;
      for (int i = 0; i < 256; i++) begin
         m.sym_tab[i] = '0;
         m.cnt_tab[i] = '0;
      end
      restart_interval(m);
   endfunction

   function automatic void apply_csr(inout dec_state_t m, input logic [1:0] idx,
                                     input logic [23:0] v);
      case (idx)
         CSR_TOTAL:   m.total   = v;
         CSR_SPECIES: m.species = v[8:0];
         CSR_BITS:    m.ibits   = v[4:0];
         default:     return;
      endcase
      restart_interval(m);
   endfunction

   function automatic int unsigned code_bit(input dec_state_t m, input int unsigned p);
      return int'((m.bbuf >> (m.fill - 1 - p)) & 64'd1);
   endfunction

   // remove one bit from the buffer, p counted from the oldest
   function automatic void drop_code_bit(inout dec_state_t m, input int unsigned p);
      int unsigned     pos;
      longint unsigned below, above;
      pos    = m.fill - 1 - p;
      below  = m.bbuf & ((64'd1 << pos) - 1);
      above  = m.bbuf >> (pos + 1);
      m.bbuf = (above << pos) | below;
      m.fill--;
   endfunction

   function automatic status_type decode_symbol(inout dec_state_t m, input logic [7:0] key,
                                                output logic [7:0] sym);
      longint unsigned lo_e [256];
      longint unsigned en_e [256];
      longint unsigned iv, quarter, half, tq, tag, tot, range, cum, c;
      int unsigned     b, n, idx_min, k, hits;
      sym     = '0;
      b       = width_of(m);
      iv      = 64'd1 << b;
      quarter = iv >> 2;
      half    = iv >> 1;
      tq      = quarter * 3;
      tag     = (m.bbuf >> (m.fill - b)) & (iv - 1);
      tot     = (m.total != 0) ? m.total : 1;
      n       = (m.species > 256) ? 256 : m.species;
      cum     = 0;
      idx_min = 0;
      k       = 0;
      hits    = 0;
      if (m.hi_b < m.lo_b || m.hi_b - m.lo_b + 1 < quarter) begin
         m.halted = 1'b1;
         return ST_MISMATCH;
      end
      range = m.hi_b - m.lo_b + 1;
      for (int i = 0; i < n; i++) begin
         c       = (cum > tot) ? tot : cum;
         lo_e[i] = m.lo_b + range * c / tot;
         cum    += m.cnt_tab[i];
         c       = (cum > tot) ? tot : cum;
         en_e[i] = m.lo_b + range * c / tot;
      end
      for (int i = 0; i < n; i++)
         if (en_e[i] > lo_e[i] && en_e[i] - lo_e[i] >= 2) idx_min = i;
      // key one nudges edges up to the last entry wider than one code
      if (key == 8'd1) begin
         for (int i = 0; i < n; i++) begin
            if (i == 0) en_e[i]++;
            else if (i == idx_min) lo_e[i]++;
            else if (i < idx_min) begin
               lo_e[i]++;
               en_e[i]++;
            end
         end
      end
      for (int i = 0; i < n; i++)
         if (tag >= lo_e[i] && tag < en_e[i]) begin
            k = i;
            hits++;
         end
      if (hits != 1) begin
         m.halted = 1'b1;
         return ST_NOMATCH;
      end
      sym = m.sym_tab[k];
      m.left--;
      m.lo_b = lo_e[k];
      m.hi_b = en_e[k] - 1;
      if (m.hi_b > iv - 1) m.hi_b = iv - 1;
      // E1 / E2 / E3 rescaling, each step checked against the code bits
      while (1) begin
         if (m.hi_b < half) begin
            if (m.fill < 1 || code_bit(m, 0) != 0) begin
               m.halted = 1'b1;
               return ST_MISMATCH;
            end
            m.lo_b = 2 * m.lo_b;
            m.hi_b = 2 * m.hi_b + 1;
            drop_code_bit(m, 0);
         end else if (m.lo_b >= half && m.hi_b < iv) begin
            if (m.fill < 1 || code_bit(m, 0) != 1) begin
               m.halted = 1'b1;
               return ST_MISMATCH;
            end
            m.lo_b = 2 * m.lo_b - iv;
            m.hi_b = 2 * m.hi_b + 1 - iv;
            drop_code_bit(m, 0);
         end else if (m.lo_b >= quarter && m.hi_b < tq) begin
            if (m.fill < 2 || code_bit(m, 0) == code_bit(m, 1)) begin
               m.halted = 1'b1;
               return ST_MISMATCH;
            end
            m.lo_b = 2 * m.lo_b - half;
            m.hi_b = 2 * m.hi_b + 1 - half;
            drop_code_bit(m, 1);
         end else begin
            break;
         end
      end
      return ST_OK;
   endfunction

   // expected answer to one beat, state advanced
   function automatic rsp_type decoder_answer(inout dec_state_t m, input req_type r);
      rsp_type    a;
      logic [7:0] sym;
      sym = '0;
      if (r.op == OP_LOAD) begin
         m.sym_tab[r.entry_index] = r.entry_symbol;
         m.cnt_tab[r.entry_index] = r.entry_count;
         a.status = ST_LOADED;
      end else if (m.halted) begin
         a.status = ST_HALT;
      end else if (r.op == OP_PUSH) begin
         if (m.fill + 8 > BUF_CAP) begin
            a.status = ST_FULL;
         end else begin
            m.bbuf  = (m.bbuf << 8) | r.data_byte;
            m.fill += 8;
            a.status = ST_TAKEN;
         end
      end else if (m.left == 0) begin
         a.status = ST_HALT;
      end else if (m.fill < width_of(m)) begin
         a.status = ST_NEED;
      end else begin
         a.status = decode_symbol(m, r.data_byte, sym);
      end
      a.symbol    = sym;
      a.remaining = m.left;
      return a;
   endfunction

   // ---------------------------------------------------------------
   // Scoreboard: its own decoder state, queue of pending answers.
   // ---------------------------------------------------------------
   class answer_board;
      dec_state_t st;
      rsp_type    pending_q [$];
      int         errors;
      int         seen [8];

      function void note(req_type r);
         pending_q.push_back(decoder_answer(st, r));
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t unexpected result beat %h", $realtime, got);
            return;
         end
         want = pending_q.pop_front();
         seen[want.status]++;
         if (got.symbol !== want.symbol || got.status !== want.status ||
             got.remaining !== want.remaining) begin
            errors++;
            if (errors <= 10)
               $display("%0t mismatch: sym %h/%h status %0d/%0d remaining %0d/%0d (exp/act)",
                        $realtime, want.symbol, got.symbol, want.status, got.status,
                        want.remaining, got.remaining);
         end
      endfunction
   endclass

   answer_board board;
   dec_state_t  plan;        // generator's view, advanced as beats go out
   int          items;
   int          idle_pct;
   int          stall_cycles;

   // results checked before a same-edge beat is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check(rsp_data);
         if (start && !busy) board.note(req_data);
      end
   end

   // watchdog: cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send(input req_type r);
      rsp_type dummy;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      dummy = decoder_answer(plan, r);
      items++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic req_type make_beat(input logic [1:0] op, input logic [7:0] idx,
                                         input logic [7:0] sym, input logic [23:0] cnt,
                                         input logic [7:0] b);
      req_type r;
      r.op           = op;
      r.entry_index  = idx;
      r.entry_symbol = sym;
      r.entry_count  = cnt;
      r.data_byte    = b;
      return r;
   endfunction

   // register write only once the block has answered everything
   task automatic write_csr(input logic [1:0] idx, input logic [23:0] v);
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(plan, idx, v);
      apply_csr(board.st, idx, v);
   endtask

   function automatic logic [7:0] pick_key();
      return ($urandom_range(9) < 3) ? 8'd1 : 8'($urandom);
   endfunction

   // Decode one symbol, first pushing code bytes that keep the stream
   // consistent where a short search finds them.
   task automatic decode_step(input logic [7:0] key, input logic [1:0] op);
      req_type    rd, p1, p2;
      dec_state_t t;
      rsp_type    a;
      rd = make_beat(op, 8'($urandom), 8'($urandom), 24'($urandom), key);
      t = plan;
      a = decoder_answer(t, rd);
      if (a.status == ST_OK) begin
         send(rd);
         return;
      end
      for (int i = 0; i < 48; i++) begin
         p1 = make_beat(OP_PUSH, 8'($urandom), 8'($urandom), 24'($urandom), 8'($urandom));
         t = plan;
         a = decoder_answer(t, p1);
         if (a.status != ST_TAKEN) break;
         a = decoder_answer(t, rd);
         if (a.status == ST_OK) begin
            send(p1);
            send(rd);
            return;
         end
      end
      for (int i = 0; i < 48; i++) begin
         p1 = make_beat(OP_PUSH, 8'($urandom), 8'($urandom), 24'($urandom), 8'($urandom));
         p2 = make_beat(OP_PUSH, 8'($urandom), 8'($urandom), 24'($urandom), 8'($urandom));
         t = plan;
         a = decoder_answer(t, p1);
         if (a.status != ST_TAKEN) break;
         a = decoder_answer(t, p2);
         if (a.status != ST_TAKEN) break;
         a = decoder_answer(t, rd);
         if (a.status == ST_OK) begin
            send(p1);
            send(p2);
            send(rd);
            return;
         end
      end
      // no consistent continuation: broken stream, usually halts
      send(make_beat(OP_PUSH, 8'($urandom), 8'($urandom), 24'($urandom), 8'($urandom)));
      send(rd);
   endtask

   // One message: registers, table, then a run of decodes.
   task automatic run_message(input int unsigned n_spec, input int unsigned max_cnt,
                              input int unsigned max_dec, input bit odd_regs);
      int unsigned     n_eff, bits, dec;
      longint unsigned sum;
      logic [23:0]     cnts [256];
      logic [23:0]     total;
      sum   = 0;
      n_eff = ((n_spec & 9'h1FF) > 256) ? 256 : (n_spec & 9'h1FF);
      for (int i = 0; i < n_eff; i++) begin
         cnts[i] = ($urandom_range(19) == 0) ? 24'd0 : 24'($urandom_range(1, max_cnt));
         sum += cnts[i];
      end
      total = (sum == 0) ? 24'd1 : (sum > 24'hFFFFFF) ? 24'hFFFFFF : 24'(sum);
      if (odd_regs && $urandom_range(1)) total = 24'($urandom_range(0, 2 * total));
      bits = $clog2(total + 1) + 2;
      if (bits > MAX_INTERVAL_BITS) bits = MAX_INTERVAL_BITS;
      if (odd_regs) bits = $urandom_range(0, 31);
      write_csr(CSR_TOTAL, total);
      write_csr(CSR_SPECIES, {15'($urandom), 9'(n_spec)});
      write_csr(CSR_BITS, {19'($urandom), 5'(bits)});
      for (int i = 0; i < n_eff; i++)
         send(make_beat(OP_LOAD, 8'(i), 8'($urandom), cnts[i], 8'($urandom)));
      dec = 0;
      while (!plan.halted && plan.left != 0 && dec < max_dec && items < 3 * ITEM_TARGET) begin
         if ($urandom_range(11) == 0)
            send(make_beat(($urandom_range(1) ? OP_PUSH : OP_DECODE), 8'($urandom),
                           8'($urandom), 24'($urandom), 8'($urandom)));
         else
            decode_step(pick_key(), ($urandom_range(7) == 0) ? OP_DECODE_ALT : OP_DECODE);
         dec++;
      end
      // closing decode beat, answered with the halt code if the block is done or halted
      send(make_beat(OP_DECODE, 8'($urandom), 8'($urandom), 24'($urandom), pick_key()));
      if (plan.halted)
         send(make_beat(OP_PUSH, 8'($urandom), 8'($urandom), 24'($urandom), 8'($urandom)));
   endtask

   initial begin
      int msg;
      board = new();
      power_on(board.st);
      power_on(plan);
      items    = 0;
      idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small table, empty buffer, buffer overflow, alias op
      write_csr(CSR_TOTAL, 24'd10);
      write_csr(CSR_SPECIES, 24'd3);
      write_csr(CSR_BITS, 24'd6);
      send(make_beat(OP_LOAD, 8'd0, 8'h00, 24'd5, 8'h00));
      send(make_beat(OP_LOAD, 8'd1, 8'hFF, 24'd3, 8'hFF));
      send(make_beat(OP_LOAD, 8'd2, 8'h5A, 24'd2, 8'h00));
      send(make_beat(OP_LOAD, 8'd255, 8'hFF, 24'hFFFFFF, 8'h00));
      send(make_beat(OP_DECODE, 8'd0, 8'd0, 24'd0, 8'd0));
      send(make_beat(OP_DECODE_ALT, 8'd0, 8'd0, 24'd0, 8'd1));
      send(make_beat(OP_PUSH, 8'd0, 8'd0, 24'd0, 8'h00));
      send(make_beat(OP_PUSH, 8'd0, 8'd0, 24'd0, 8'hFF));
      send(make_beat(OP_PUSH, 8'd0, 8'd0, 24'd0, 8'h55));
      send(make_beat(OP_PUSH, 8'd0, 8'd0, 24'd0, 8'hAA));
      send(make_beat(OP_PUSH, 8'd0, 8'd0, 24'd0, 8'h3C));
      decode_step(8'd1, OP_DECODE);
      decode_step(8'd0, OP_DECODE);
      decode_step(8'hFF, OP_DECODE_ALT);

      // corner configurations: single entry, empty table, oversized
      // species count, full table, largest counts and odd registers
      run_message(1, 100, 6, 1'b0);
      run_message(0, 10, 2, 1'b0);
      run_message(300, 1000, 2, 1'b0);
      run_message(256, 65535, 3, 1'b0);
      run_message(2, 24'hFFFFFF, 8, 1'b0);
      run_message(4, 24'hFFFFFF, 8, 1'b1);

      msg = 0;
      while (items < ITEM_TARGET) begin
         case (msg % 4)
            1:       idle_pct = 47;
            3:       idle_pct = 19;
            default: idle_pct = 0;
         endcase
         if (msg % 9 == 8)
            run_message($urandom_range(2, 6), 1 << $urandom_range(1, 23), 30, 1'b1);
         else
            run_message($urandom_range(2, 12), ($urandom_range(3) == 0) ? 4000 : 40,
                        60, 1'b0);
         msg++;
      end

      start <= 1'b0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d beats over %0d messages: %0d symbols, %0d no-match, %0d mismatch",
               items, msg + 6, board.seen[ST_OK], board.seen[ST_NOMATCH],
               board.seen[ST_MISMATCH]);
      $display("also %0d short-buffer, %0d full-buffer, %0d halted answers; %0d errors",
               board.seen[ST_NEED], board.seen[ST_FULL], board.seen[ST_HALT], board.errors);
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/kad_pkg.sv
rtl/core/kad_ram.sv
rtl/core/kad_datapath.sv
rtl/core/kad_ctrl.sv
rtl/core/keyed_arithmetic_decoder.sv
rtl/core/kad_checker.sv
tb/sv/keyed_arithmetic_decoder_test.sv
